/* sv/rle_gpe_pkg.sv */
// ----------------------------------------------------------------------------
// rle_gpe_pkg
// Shared types and constants of the run-length glyph pixel expander.
// ----------------------------------------------------------------------------
package rle_gpe_pkg;

    localparam int PIXEL_W          = 16;
    localparam int CODE_W           = 8;
    localparam int WIDTH_W          = 7;
    localparam int HEIGHT_W         = 7;
    localparam int RUN_W            = 8;
    localparam int COUNT_W          = 14;
    localparam int CFG_DATA_W       = 16;
    localparam int CFG_IDX_W        = 2;
    localparam int MAX_GLYPH_PIXELS = 1024;

    localparam logic [COUNT_W-1:0] MAX_PIXELS_C = COUNT_W'(MAX_GLYPH_PIXELS);

    localparam logic [PIXEL_W-1:0]  FG_RESET     = 16'hFFFF;
    localparam logic [PIXEL_W-1:0]  BG_RESET     = 16'h0000;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 7'd32;

    typedef logic [PIXEL_W-1:0] pixel_t;
    typedef logic [COUNT_W-1:0] count_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FOREGROUND = 2'd0,
        REG_BACKGROUND = 2'd1,
        REG_HEIGHT     = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic load;
        logic advance;
    } cmd_t;

    typedef struct packed {
        logic last;
    } status_t;

endpackage

/* sv/rle_gpe_in_if.sv */
// ----------------------------------------------------------------------------
// rle_gpe_in_if
// Input channel: one run-length byte and the glyph width per item.
// ----------------------------------------------------------------------------
interface rle_gpe_in_if
    import rle_gpe_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [CODE_W-1:0]   rle_byte;
    logic [WIDTH_W-1:0]  glyph_width;

    modport source (output valid, output rle_byte, output glyph_width, input ready);
    modport sink   (input valid, input rle_byte, input glyph_width, output ready);
endinterface

/* sv/rle_gpe_out_if.sv */
// ----------------------------------------------------------------------------
// rle_gpe_out_if
// Output channel: one pixel pair with run and glyph flags per item.
// ----------------------------------------------------------------------------
interface rle_gpe_out_if
    import rle_gpe_pkg::*;
;
    logic   valid;
    logic   ready;
    pixel_t pixel_first;
    pixel_t pixel_second;
    logic   second_valid;
    logic   last_of_run;
    logic   glyph_done;
    logic   overflow;

    modport source (output valid, output pixel_first, output pixel_second,
                    output second_valid, output last_of_run, output glyph_done,
                    output overflow, input ready);
    modport sink   (input valid, input pixel_first, input pixel_second,
                    input second_valid, input last_of_run, input glyph_done,
                    input overflow, output ready);
endinterface

/* sv/rle_gpe_ctrl.sv */
// ----------------------------------------------------------------------------
// rle_gpe_ctrl
// Controller: loads a byte, then steps the datapath once per taken pair.
// ----------------------------------------------------------------------------
module rle_gpe_ctrl
    import rle_gpe_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        out_valid   = (state_reg == ST_EMIT);
        cmd.advance = out_valid && out_ready;
        in_ready    = (state_reg == ST_IDLE) || (cmd.advance && status.last);
        cmd.load    = in_valid && in_ready;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.load)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (cmd.load)
                begin
                    state_next = ST_EMIT;
                end
                else if (cmd.advance && status.last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* sv/rle_gpe_dp.sv */
// ----------------------------------------------------------------------------
// rle_gpe_dp
// Datapath: colour registers, run counter, glyph pixel count and flags.
// ----------------------------------------------------------------------------
module rle_gpe_dp
    import rle_gpe_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [CODE_W-1:0]     rle_byte,
    input  logic [WIDTH_W-1:0]    glyph_width,
    input  cmd_t                  cmd,
    output status_t               status,
    output pixel_t                pixel_first,
    output pixel_t                pixel_second,
    output logic                  second_valid,
    output logic                  last_of_run,
    output logic                  glyph_done,
    output logic                  overflow
);

    pixel_t              fg_reg;
    pixel_t              bg_reg;
    logic [HEIGHT_W-1:0] height_reg;
    pixel_t              colour_reg;
    pixel_t              colour_next;
    logic [RUN_W-1:0]    left_reg;
    logic [RUN_W-1:0]    left_next;
    count_t              count_reg;
    count_t              count_next;
    count_t              total_reg;
    count_t              total_next;
    count_t              count_inc;
    logic                take_two;
    logic                last;

    always_comb
    begin
        take_two  = (left_reg >= RUN_W'(2));
        last      = (left_reg <= RUN_W'(2));
        count_inc = count_reg + (take_two ? COUNT_W'(2) : COUNT_W'(1));

        pixel_first   = colour_reg;
        pixel_second  = take_two ? colour_reg : '0;
        second_valid  = take_two;
        last_of_run   = last;
        glyph_done    = last && (count_inc >= total_reg);
        overflow      = (count_inc > MAX_PIXELS_C);
        status.last   = last;
    end

    always_comb
    begin
        colour_next = colour_reg;
        left_next   = left_reg;
        count_next  = count_reg;
        total_next  = total_reg;
        if (cmd.advance)
        begin
            left_next  = left_reg - (take_two ? RUN_W'(2) : RUN_W'(1));
            count_next = glyph_done ? '0 : count_inc;
        end
        if (cmd.load)
        begin
            colour_next = rle_byte[CODE_W-1] ? fg_reg : bg_reg;
            left_next   = {1'b0, rle_byte[CODE_W-2:0]} + RUN_W'(1);
            total_next  = {{(COUNT_W-WIDTH_W){1'b0}}, glyph_width}
                        * {{(COUNT_W-HEIGHT_W){1'b0}}, height_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fg_reg     <= FG_RESET;
            bg_reg     <= BG_RESET;
            height_reg <= HEIGHT_RESET;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_FOREGROUND: fg_reg     <= cfg_data;
                    REG_BACKGROUND: bg_reg     <= cfg_data;
                    REG_HEIGHT:     height_reg <= cfg_data[HEIGHT_W-1:0];
                    default:        ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        colour_reg <= colour_next;
        left_reg   <= left_next;
        total_reg  <= total_next;
    end

endmodule

/* sv/rle_glyph_pixel_expander_core.sv */
// ----------------------------------------------------------------------------
// rle_glyph_pixel_expander_core
// Expands run-length font glyph bytes into pairs of RGB565 pixels.
//
// in_ch takes one item per byte: rle_byte (bit 7 picks foreground or
// background, bits 6..0 give run length minus one) and glyph_width.
// out_ch gives one item per pixel pair; an odd run ends with a single pixel
// (second_valid low). last_of_run marks the final item of a byte, glyph_done
// marks it when the glyph total width * height is reached, and overflow
// flags items whose pixels lie past the buffer size.
// The cfg port writes foreground colour, background colour and glyph height;
// the user must write it only while the block is idle (not enforced here).
// The first item of a byte is offered in the cycle after its acceptance.
// A byte of run length N gives ceil(N/2) items, one pair per cycle while the
// receiver is ready, from the single run counter; the next byte is taken in
// the cycle the last item of the current one leaves, so 1 to 64 items a byte.
// Reset clears the pixel count and restores the register defaults. While
// the receiver stalls the current item is held and no byte is taken.
// ----------------------------------------------------------------------------
module rle_glyph_pixel_expander_core
    import rle_gpe_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    rle_gpe_in_if.sink            in_ch,
    rle_gpe_out_if.source         out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cmd_t    cmd;
    status_t status;

    rle_gpe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    rle_gpe_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .rle_byte     (in_ch.rle_byte),
        .glyph_width  (in_ch.glyph_width),
        .cmd          (cmd),
        .status       (status),
        .pixel_first  (out_ch.pixel_first),
        .pixel_second (out_ch.pixel_second),
        .second_valid (out_ch.second_valid),
        .last_of_run  (out_ch.last_of_run),
        .glyph_done   (out_ch.glyph_done),
        .overflow     (out_ch.overflow)
    );

endmodule
